[rtl/core/bpwm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bpwm_pkg: shared types and constants for the busy pin wait monitor
// Beat payload structs, status and mode codes, register indexes and
// register reset values.
// -----------------------------------------------------------------------------
package bpwm_pkg;

   // Opcodes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   // Wait modes (the unused code behaves as two-phase)
   localparam logic [1:0] MODE_HIGH      = 2'd0;
   localparam logic [1:0] MODE_LOW       = 2'd1;
   localparam logic [1:0] MODE_TWO_PHASE = 2'd2;

   // Status / phase codes
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_ASSERT  = 3'd1;
   localparam logic [2:0] PH_RELEASE = 3'd2;
   localparam logic [2:0] PH_DONE    = 3'd3;
   localparam logic [2:0] PH_TIMEOUT = 3'd4;
   localparam logic [2:0] PH_NEVER   = 3'd5;

   // Register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_HOOK_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_WINDOW   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_WINDOW    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BEGIN_HOOK_EN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_END_HOOK_EN    = 3'd5;

   localparam int unsigned MS_W = 16;

   // Register reset values
   localparam logic [MS_W-1:0] RST_HOOK_THRESHOLD = 16'd1000;
   localparam logic [MS_W-1:0] RST_TIMEOUT        = 16'd30000;
   localparam logic [MS_W-1:0] RST_START_WINDOW   = 16'd100;
   localparam logic [MS_W-1:0] RST_EDGE_WINDOW    = 16'd1000;

   typedef struct packed {
      logic       opcode;
      logic       busy_level;
      logic [1:0] wait_mode;
   } req_type;

   typedef struct packed {
      logic [2:0]      status;
      logic            hook_begin;
      logic            hook_end;
      logic [MS_W-1:0] elapsed_ms;
   } rsp_type;

   typedef struct packed {
      logic [MS_W-1:0] hook_threshold_ms;
      logic [MS_W-1:0] timeout_ms;
      logic [MS_W-1:0] start_window_ms;
      logic [MS_W-1:0] edge_window_ms;
      logic            begin_hook_enabled;
      logic            end_hook_enabled;
   } cfg_type;

   typedef struct packed {
      logic [2:0] phase;
      logic [1:0] active_mode;
      logic       long_wait;
      logic       hook_fired;
   } ctl_type;

endpackage
`default_nettype wire

[rtl/core/busy_pin_wait_monitor.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// busy_pin_wait_monitor: busy line wait with timeout and long-wait hooks
// Tracks a display controller busy line one millisecond tick per beat.
// -----------------------------------------------------------------------------
// Usage: send a start beat (opcode 1) with the wait mode and the current pin
// level, then one tick beat (opcode 0) per millisecond with the sampled level.
// Every request beat yields exactly one response beat carrying the wait
// status, the begin/end hook pulses and the saturating elapsed count. The
// block takes one request beat per clock and the response appears on the
// next clock: the wait state update is a single compare-and-increment stage
// that feeds the response register, and the response register is the only
// thing that can stall intake (a beat is taken whenever that register is
// empty or being drained the same cycle). Registers are written through the
// csr_ port (always ready) and should only be changed while no wait beat is
// in flight.
// -----------------------------------------------------------------------------
module busy_pin_wait_monitor
   import bpwm_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  wire                        clock,
   input  wire                        reset,
   // request channel
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire  req_type              req_payload,
   // response channel
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output rsp_type                    rsp_payload,
   // register write channel
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire  logic [CSR_IDX_W-1:0] csr_index,
   input  wire  logic [MS_W-1:0]      csr_data
);

   cfg_type                cfg_ff;
   ctl_type                ctl_ff;
   ctl_type                ctl_in;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;
   logic                   rsp_valid_ff;
   logic                   req_take;

   // Take a beat whenever the response register is free or drains now
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   bpwm_step #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_step (
      .cfg       (cfg_ff),
      .ctl       (ctl_ff),
      .count     (count_ff),
      .req       (req_payload),
      .ctl_next  (ctl_in),
      .count_next(count_in),
      .rsp       (rsp_in)
   );

   // Register file: write on a csr beat, drop writes to unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hook_threshold_ms  <= RST_HOOK_THRESHOLD;
         cfg_ff.timeout_ms         <= RST_TIMEOUT;
         cfg_ff.start_window_ms    <= RST_START_WINDOW;
         cfg_ff.edge_window_ms     <= RST_EDGE_WINDOW;
         cfg_ff.begin_hook_enabled <= 1'b0;
         cfg_ff.end_hook_enabled   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HOOK_THRESHOLD: cfg_ff.hook_threshold_ms  <= csr_data;
            CSR_TIMEOUT:        cfg_ff.timeout_ms         <= csr_data;
            CSR_START_WINDOW:   cfg_ff.start_window_ms    <= csr_data;
            CSR_EDGE_WINDOW:    cfg_ff.edge_window_ms     <= csr_data;
            CSR_BEGIN_HOOK_EN:  cfg_ff.begin_hook_enabled <= csr_data[0];
            CSR_END_HOOK_EN:    cfg_ff.end_hook_enabled   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Wait state: advance on every accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff   <= '{phase: PH_IDLE, active_mode: MODE_HIGH,
                       long_wait: 1'b0, hook_fired: 1'b0};
         count_ff <= '0;
      end else if (req_take) begin
         ctl_ff   <= ctl_in;
         count_ff <= count_in;
      end
   end

   // Response register: load on intake, drop valid when drained
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

[rtl/core/bpwm_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bpwm_step: next-state and result logic for one beat
// Applies a tick or start beat to the wait state and forms the result.
// -----------------------------------------------------------------------------
module bpwm_step
   import bpwm_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  wire  cfg_type                cfg,
   input  wire  ctl_type                ctl,
   input  wire  logic [COUNT_WIDTH-1:0] count,
   input  wire  req_type                req,
   output ctl_type                      ctl_next,
   output logic [COUNT_WIDTH-1:0]       count_next,
   output rsp_type                      rsp
);

   localparam int unsigned CMP_W = (COUNT_WIDTH > MS_W) ? COUNT_WIDTH : MS_W;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   logic [COUNT_WIDTH-1:0] count_inc;
   logic [CMP_W-1:0]       cnt_x;
   logic [CMP_W-1:0]       out_x;
   logic                   fired;
   logic                   active_lvl;

   assign count_inc = (count != COUNT_MAX) ? count + 1'b1 : count;
   assign cnt_x     = CMP_W'(count_inc);

   always_comb begin
      ctl_next       = ctl;
      count_next     = count;
      rsp.hook_begin = 1'b0;
      rsp.hook_end   = 1'b0;
      fired          = ctl.hook_fired;
      active_lvl     = (ctl.active_mode == MODE_HIGH);
      if (req.opcode == OP_START) begin
         ctl_next.active_mode = req.wait_mode;
         ctl_next.long_wait   = 1'b0;
         ctl_next.hook_fired  = 1'b0;
         count_next           = '0;
         case (req.wait_mode)
            MODE_HIGH: begin
               ctl_next.phase = req.busy_level ? PH_RELEASE : PH_NEVER;
            end
            MODE_LOW: begin
               if (!req.busy_level)
                  ctl_next.phase = PH_RELEASE;
               else
                  ctl_next.phase = (cfg.start_window_ms == '0) ? PH_NEVER : PH_ASSERT;
            end
            default: begin
               ctl_next.phase = req.busy_level ? PH_ASSERT : PH_RELEASE;
            end
         endcase
      end else if (ctl.phase == PH_ASSERT) begin
         count_next = count_inc;
         if (ctl.active_mode == MODE_LOW) begin
            if (cnt_x < CMP_W'(cfg.start_window_ms)) begin
               if (!req.busy_level) ctl_next.phase = PH_RELEASE;
            end else begin
               ctl_next.phase = PH_NEVER;
               rsp.hook_end   = fired & cfg.end_hook_enabled;
            end
         end else begin
            if (!req.busy_level) begin
               ctl_next.phase = PH_RELEASE;
            end else if (cnt_x > CMP_W'(cfg.edge_window_ms)) begin
               ctl_next.phase = PH_NEVER;
               rsp.hook_end   = fired & cfg.end_hook_enabled;
            end
         end
      end else if (ctl.phase == PH_RELEASE) begin
         count_next = count_inc;
         if (req.busy_level != active_lvl) begin
            ctl_next.phase = PH_DONE;
            rsp.hook_end   = fired & cfg.end_hook_enabled;
         end else begin
            if (!ctl.long_wait && cnt_x > CMP_W'(cfg.hook_threshold_ms)) begin
               ctl_next.long_wait = 1'b1;
               if (cfg.begin_hook_enabled) begin
                  fired          = 1'b1;
                  rsp.hook_begin = 1'b1;
               end
            end
            ctl_next.hook_fired = fired;
            if (cnt_x > CMP_W'(cfg.timeout_ms)) begin
               ctl_next.phase = PH_TIMEOUT;
               rsp.hook_end   = fired & cfg.end_hook_enabled;
            end
         end
      end
      // Saturate the reported count at the width of the output field
      out_x          = CMP_W'(count_next);
      rsp.status     = ctl_next.phase;
      rsp.elapsed_ms = (out_x > CMP_W'({MS_W{1'b1}})) ? {MS_W{1'b1}} : out_x[MS_W-1:0];
   end

endmodule
`default_nettype wire
